@@ rtl/sgcp_pkg.sv @@
// shared types and constants for the superio gpio configuration port
// no dependencies; used by every module under rtl

package sgcp_pkg;

    // gpio sets and pin counts
    localparam int GPIO_SETS = 5;
    localparam int SET_W     = (GPIO_SETS > 1) ? $clog2(GPIO_SETS) : 1;
    localparam int PIN_BITS  = 40;
    localparam int PIN_SETS  = PIN_BITS / 8;
    localparam int DRV_SETS  = (GPIO_SETS < PIN_SETS) ? GPIO_SETS : PIN_SETS;

    // i/o port addresses
    localparam logic [15:0] IDX_PORT = 16'h002E;
    localparam logic [15:0] DAT_PORT = 16'h002F;

    // unlock key bytes
    localparam logic [7:0] KEY_BYTE_0 = 8'h87;
    localparam logic [7:0] KEY_BYTE_1 = 8'h01;
    localparam logic [7:0] KEY_BYTE_2 = 8'h55;
    localparam logic [7:0] KEY_BYTE_3 = 8'h55;

    // configuration space register indexes
    localparam logic [7:0] REG_EXIT    = 8'h02;
    localparam logic [7:0] EXIT_VALUE  = 8'h02;
    localparam logic [7:0] REG_LDN     = 8'h07;
    localparam logic [7:0] REG_CHIP_HI = 8'h20;
    localparam logic [7:0] REG_CHIP_LO = 8'h21;
    localparam logic [7:0] REG_BASE_HI = 8'h62;
    localparam logic [7:0] REG_BASE_LO = 8'h63;
    localparam logic [7:0] GPIO_LDN    = 8'h07;

    // bank groups, upper five bits of the register index
    localparam logic [4:0] BANK_POL = 5'(8'hB0 >> 3);
    localparam logic [4:0] BANK_PUP = 5'(8'hB8 >> 3);
    localparam logic [4:0] BANK_SIO = 5'(8'hC0 >> 3);
    localparam logic [4:0] BANK_OE  = 5'(8'hC8 >> 3);

    // unmapped read value
    localparam logic [7:0] READ_MISS = 8'hFF;

    // host configuration register indexes and reset values
    localparam logic        CFG_CHIP_ID      = 1'b0;
    localparam logic        CFG_BASE_DEFAULT = 1'b1;
    localparam logic [15:0] CHIP_ID_RESET    = 16'h8783;
    localparam logic [15:0] BASE_RESET       = 16'h0A00;

    // bus access kind
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // unlock sequence progress
    typedef enum logic [1:0] {
        KEY_IDLE,
        KEY_GOT_1,
        KEY_GOT_2,
        KEY_GOT_3
    } key_state_t;

    typedef struct packed {
        logic                req_type;
        logic [15:0]         io_address;
        logic [7:0]          write_data;
        logic [PIN_BITS-1:0] pin_levels;
    } sgcp_req_t;

    typedef struct packed {
        logic [7:0]          read_data;
        logic                address_hit;
        logic                config_unlocked;
        logic [PIN_BITS-1:0] pin_drive;
        logic [PIN_BITS-1:0] pin_drive_enable;
    } sgcp_rsp_t;

    typedef struct packed {
        logic        we;
        logic        index;
        logic [15:0] wdata;
    } sgcp_cfg_wr_t;

endpackage

@@ rtl/sgcp_key_match.sv @@
// unlock key sequence matcher for the configuration index port
// depends on sgcp_pkg

module sgcp_key_match (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       feed,
    input  logic [7:0] key_byte,
    output logic       unlock
);

    sgcp_pkg::key_state_t state_reg;
    sgcp_pkg::key_state_t state_next;
    logic                 restart_87;

    assign restart_87 = (key_byte == sgcp_pkg::KEY_BYTE_0);

    // next state: advance on a match, otherwise restart the match
    always_comb
    begin
        state_next = state_reg;
        if (feed)
        begin
            unique case (state_reg)
                sgcp_pkg::KEY_IDLE:
                begin
                    state_next = restart_87 ? sgcp_pkg::KEY_GOT_1 : sgcp_pkg::KEY_IDLE;
                end
                sgcp_pkg::KEY_GOT_1:
                begin
                    if (key_byte == sgcp_pkg::KEY_BYTE_1)
                        state_next = sgcp_pkg::KEY_GOT_2;
                    else
                        state_next = restart_87 ? sgcp_pkg::KEY_GOT_1 : sgcp_pkg::KEY_IDLE;
                end
                sgcp_pkg::KEY_GOT_2:
                begin
                    if (key_byte == sgcp_pkg::KEY_BYTE_2)
                        state_next = sgcp_pkg::KEY_GOT_3;
                    else
                        state_next = restart_87 ? sgcp_pkg::KEY_GOT_1 : sgcp_pkg::KEY_IDLE;
                end
                sgcp_pkg::KEY_GOT_3:
                begin
                    if (key_byte == sgcp_pkg::KEY_BYTE_3)
                        state_next = sgcp_pkg::KEY_IDLE;
                    else
                        state_next = restart_87 ? sgcp_pkg::KEY_GOT_1 : sgcp_pkg::KEY_IDLE;
                end
                default:
                begin
                    state_next = sgcp_pkg::KEY_IDLE;
                end
            endcase
        end
    end

    // output: last key byte completes the sequence
    always_comb
    begin
        unlock = feed && (state_reg == sgcp_pkg::KEY_GOT_3)
                 && (key_byte == sgcp_pkg::KEY_BYTE_3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sgcp_pkg::KEY_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/sgcp_core.sv @@
// access decode, configuration space and gpio state for one bus transaction
// depends on sgcp_pkg and sgcp_key_match

module sgcp_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  sgcp_pkg::sgcp_req_t    req,
    input  sgcp_pkg::sgcp_cfg_wr_t cfg,
    output sgcp_pkg::sgcp_rsp_t    rsp
);

    localparam int NS = sgcp_pkg::GPIO_SETS;
    localparam int SW = sgcp_pkg::SET_W;

    // host registers
    logic [15:0] chip_id_reg;

    // device state
    logic        unlocked_reg, unlocked_next;
    logic [7:0]  index_reg, index_next;
    logic [7:0]  ldn_reg, ldn_next;
    logic [15:0] gpio_base_reg, gpio_base_next;
    logic [7:0]  pol_reg [NS];
    logic [7:0]  pol_next [NS];
    logic [7:0]  pup_reg [NS];
    logic [7:0]  pup_next [NS];
    logic [7:0]  sio_reg [NS];
    logic [7:0]  sio_next [NS];
    logic [7:0]  oe_reg [NS];
    logic [7:0]  oe_next [NS];
    logic [7:0]  latch_reg [NS];
    logic [7:0]  latch_next [NS];

    // decode
    logic          is_wr, is_idx, is_dat, in_win;
    logic [15:0]   win_off;
    logic [SW-1:0] win_set;
    logic [SW-1:0] bank_set;
    logic          bank_ok, ldn_gpio;
    logic [4:0]    bank_grp;
    logic          key_feed, key_unlock;
    logic [7:0]    pin_lane [NS];
    logic [7:0]    rd;
    logic          hit;

    assign is_wr    = (req.req_type == sgcp_pkg::REQ_WRITE);
    assign is_idx   = (req.io_address == sgcp_pkg::IDX_PORT);
    assign is_dat   = (req.io_address == sgcp_pkg::DAT_PORT);
    assign win_off  = req.io_address - gpio_base_reg;
    assign in_win   = (win_off < 16'(NS));
    assign win_set  = win_off[SW-1:0];
    assign bank_grp = index_reg[7:3];
    assign bank_set = index_reg[SW-1:0];
    assign bank_ok  = (32'(index_reg[2:0]) < NS);
    assign ldn_gpio = (ldn_reg == sgcp_pkg::GPIO_LDN);
    assign key_feed = step && is_idx && is_wr && !unlocked_reg;

    sgcp_key_match u_key (
        .clk      (clk),
        .rst_n    (rst_n),
        .feed     (key_feed),
        .key_byte (req.write_data),
        .unlock   (key_unlock)
    );

    // pin levels per set, sets past the pin field read zero
    for (genvar s = 0; s < NS; s++)
    begin : g_lane
        if (s < sgcp_pkg::PIN_SETS)
        begin : g_pin
            assign pin_lane[s] = req.pin_levels[s*8 +: 8];
        end
        else
        begin : g_nopin
            assign pin_lane[s] = 8'h00;
        end
    end

    // next state for write transactions
    always_comb
    begin
        unlocked_next  = unlocked_reg;
        index_next     = index_reg;
        ldn_next       = ldn_reg;
        gpio_base_next = gpio_base_reg;
        pol_next       = pol_reg;
        pup_next       = pup_reg;
        sio_next       = sio_reg;
        oe_next        = oe_reg;
        latch_next     = latch_reg;
        if (is_idx)
        begin
            if (is_wr && unlocked_reg)
                index_next = req.write_data;
            if (key_unlock)
                unlocked_next = 1'b1;
        end
        else if (is_dat)
        begin
            if (is_wr && unlocked_reg)
            begin
                if (index_reg == sgcp_pkg::REG_EXIT)
                begin
                    if (req.write_data == sgcp_pkg::EXIT_VALUE)
                        unlocked_next = 1'b0;
                end
                else if (index_reg == sgcp_pkg::REG_LDN)
                begin
                    ldn_next = req.write_data;
                end
                else if (ldn_gpio)
                begin
                    if (index_reg == sgcp_pkg::REG_BASE_HI)
                        gpio_base_next = {req.write_data, gpio_base_reg[7:0]};
                    else if (index_reg == sgcp_pkg::REG_BASE_LO)
                        gpio_base_next = {gpio_base_reg[15:8], req.write_data};
                    else if (bank_ok)
                    begin
                        if (bank_grp == sgcp_pkg::BANK_POL)
                            pol_next[bank_set] = req.write_data;
                        else if (bank_grp == sgcp_pkg::BANK_PUP)
                            pup_next[bank_set] = req.write_data;
                        else if (bank_grp == sgcp_pkg::BANK_SIO)
                            sio_next[bank_set] = req.write_data;
                        else if (bank_grp == sgcp_pkg::BANK_OE)
                            oe_next[bank_set] = req.write_data;
                    end
                end
            end
        end
        else if (in_win && is_wr)
        begin
            latch_next[win_set] = req.write_data;
        end
    end

    // read data and address hit
    always_comb
    begin
        rd  = is_wr ? 8'h00 : sgcp_pkg::READ_MISS;
        hit = 1'b0;
        if (is_idx)
        begin
            hit = 1'b1;
            if (!is_wr && unlocked_reg)
                rd = index_reg;
        end
        else if (is_dat)
        begin
            hit = 1'b1;
            if (!is_wr && unlocked_reg)
            begin
                if (index_reg == sgcp_pkg::REG_LDN)
                    rd = ldn_reg;
                else if (index_reg == sgcp_pkg::REG_CHIP_HI)
                    rd = chip_id_reg[15:8];
                else if (index_reg == sgcp_pkg::REG_CHIP_LO)
                    rd = chip_id_reg[7:0];
                else if (ldn_gpio)
                begin
                    if (index_reg == sgcp_pkg::REG_BASE_HI)
                        rd = gpio_base_reg[15:8];
                    else if (index_reg == sgcp_pkg::REG_BASE_LO)
                        rd = gpio_base_reg[7:0];
                    else if (bank_ok)
                    begin
                        if (bank_grp == sgcp_pkg::BANK_POL)
                            rd = pol_reg[bank_set];
                        else if (bank_grp == sgcp_pkg::BANK_PUP)
                            rd = pup_reg[bank_set];
                        else if (bank_grp == sgcp_pkg::BANK_SIO)
                            rd = sio_reg[bank_set];
                        else if (bank_grp == sgcp_pkg::BANK_OE)
                            rd = oe_reg[bank_set];
                    end
                end
            end
        end
        else if (in_win)
        begin
            hit = 1'b1;
            if (!is_wr)
                rd = (latch_reg[win_set] & oe_reg[win_set])
                     | ((pin_lane[win_set] ^ pol_reg[win_set]) & ~oe_reg[win_set]);
        end
    end

    // result, pin outputs reflect the state after this transaction
    always_comb
    begin
        rsp                  = '0;
        rsp.read_data        = rd;
        rsp.address_hit      = hit;
        rsp.config_unlocked  = unlocked_next;
        for (int s = 0; s < sgcp_pkg::DRV_SETS; s++)
        begin
            rsp.pin_drive[s*8 +: 8]        = latch_next[s];
            rsp.pin_drive_enable[s*8 +: 8] = oe_next[s] & sio_next[s];
        end
    end

    // host registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chip_id_reg <= sgcp_pkg::CHIP_ID_RESET;
        else if (cfg.we && (cfg.index == sgcp_pkg::CFG_CHIP_ID))
            chip_id_reg <= cfg.wdata;
    end

    // gpio base, reloaded on a host write of the default
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gpio_base_reg <= sgcp_pkg::BASE_RESET;
        else if (cfg.we && (cfg.index == sgcp_pkg::CFG_BASE_DEFAULT))
            gpio_base_reg <= cfg.wdata;
        else if (step)
            gpio_base_reg <= gpio_base_next;
    end

    // device state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unlocked_reg <= 1'b0;
            index_reg    <= 8'h00;
            ldn_reg      <= 8'h00;
            for (int s = 0; s < NS; s++)
            begin
                pol_reg[s]   <= 8'h00;
                pup_reg[s]   <= 8'h00;
                sio_reg[s]   <= 8'h00;
                oe_reg[s]    <= 8'h00;
                latch_reg[s] <= 8'h00;
            end
        end
        else if (step)
        begin
            unlocked_reg <= unlocked_next;
            index_reg    <= index_next;
            ldn_reg      <= ldn_next;
            pol_reg      <= pol_next;
            pup_reg      <= pup_next;
            sio_reg      <= sio_next;
            oe_reg       <= oe_next;
            latch_reg    <= latch_next;
        end
    end

endmodule

@@ rtl/superio_gpio_config_port.sv @@
// an accepted request waits in the request register until the result register is free
// throughput: one transaction per cycle unless out_ready stalls, set by the two registers
// the device state is updated in the single pass between those two registers
// reset: asynchronous active-low; configuration locked, banks and latches cleared,
// chip id 0x8783 and gpio base 0x0A00; no clearing pass, ready right after reset
// depends on sgcp_pkg and sgcp_core

module superio_gpio_config_port (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sgcp_pkg::sgcp_req_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sgcp_pkg::sgcp_rsp_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wdata
);

    logic                   req_valid_reg;
    sgcp_pkg::sgcp_req_t    req_reg;
    logic                   rsp_valid_reg;
    sgcp_pkg::sgcp_rsp_t    rsp_reg;
    sgcp_pkg::sgcp_rsp_t    rsp_next;
    sgcp_pkg::sgcp_cfg_wr_t cfg;
    logic                   step;
    logic                   accept;

    // request moves into the result register when that register is free
    assign step     = req_valid_reg && (!rsp_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || step;
    assign accept   = in_valid && in_ready;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    sgcp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (req_reg),
        .cfg   (cfg),
        .rsp   (rsp_next)
    );

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (accept)
            req_valid_reg <= 1'b1;
        else if (step)
            req_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= in_data;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (step)
            rsp_valid_reg <= 1'b1;
        else if (out_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            rsp_reg <= rsp_next;
    end

    assign out_valid = rsp_valid_reg;
    assign out_data  = rsp_reg;

endmodule
